// ===== src/cfp_pkg.sv =====
// Shared constants, types and helper functions of the command frame parser.
package cfp_pkg;

  localparam int FRAME_MAX_DEFAULT = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int COUNT_W = 4;

  localparam logic [7:0] CMD_POWER = 8'h66;
  localparam logic [7:0] CMD_SETPARAM = 8'h99;

  localparam logic [7:0] ID_KP = 8'h33;
  localparam logic [7:0] ID_KI = 8'h55;
  localparam logic [7:0] ID_KD = 8'h99;
  localparam logic [7:0] ID_TT = 8'hAA;
  localparam logic [7:0] ID_ST = 8'h66;
  localparam logic [7:0] ID_AR = 8'hCC;

  localparam logic [COUNT_W-1:0] LEN_NONE = 4'd0;
  localparam logic [COUNT_W-1:0] LEN_POWER = 4'd5;
  localparam logic [COUNT_W-1:0] LEN_GAIN = 4'd10;
  localparam logic [COUNT_W-1:0] LEN_BYTE = 4'd7;

  localparam logic [2:0] KIND_KP = 3'd0;
  localparam logic [2:0] KIND_KI = 3'd1;
  localparam logic [2:0] KIND_KD = 3'd2;
  localparam logic [2:0] KIND_TT = 3'd3;
  localparam logic [2:0] KIND_ST = 3'd4;
  localparam logic [2:0] KIND_AR = 3'd5;
  localparam logic [2:0] KIND_NONE = 3'd6;

  // One completed frame, classified and checked, waiting to be carried out.
  typedef struct packed {
    logic        is_set;
    logic        ok;
    logic [7:0]  seq;
    logic [2:0]  kind;
    logic [31:0] value;
  } frame_rec_t;

  function automatic logic [2:0] id_kind(input logic [7:0] id);
    logic [2:0] k;
    unique case (id)
      ID_KP:   k = KIND_KP;
      ID_KI:   k = KIND_KI;
      ID_KD:   k = KIND_KD;
      ID_TT:   k = KIND_TT;
      ID_ST:   k = KIND_ST;
      ID_AR:   k = KIND_AR;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== src/cfp_front.sv =====
// Front end: collects frame bytes, decodes the length, keeps the checksum, emits frame records.
module cfp_front
  import cfp_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       q_full,
  output logic       push,
  output frame_rec_t push_rec
);

  localparam int IDX_W = $clog2(FRAME_MAX);

  logic [7:0] frame_store [FRAME_MAX];
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] frame_length;
  logic [7:0] running_sum;

  logic [COUNT_W-1:0] byte_count_next;
  logic [COUNT_W-1:0] frame_length_next;
  logic [7:0] running_sum_next;

  logic             take;
  logic             in_store;
  logic             cmd_set;
  logic [2:0]       rx_kind;
  logic [COUNT_W-1:0] len_eff;
  logic             drop;
  logic             add_sum;
  logic             last;
  logic [COUNT_W-1:0] count_inc;
  logic [IDX_W-1:0] chk_idx;
  logic             ok;
  logic [2:0]       stored_kind;

  assign in_ready = !q_full;
  assign take = in_valid && in_ready;
  assign in_store = ({1'b0, byte_count} < 5'(FRAME_MAX));
  assign cmd_set = (frame_store[1] == CMD_SETPARAM);
  assign rx_kind = id_kind(rx_byte);
  assign count_inc = byte_count + 4'd1;

  always_comb begin
    len_eff = frame_length;
    drop = 1'b0;
    if (byte_count == 4'd1) begin
      if (rx_byte == CMD_POWER) begin
        len_eff = LEN_POWER;
      end else if (rx_byte != CMD_SETPARAM) begin
        drop = 1'b1;
      end
    end else if (byte_count == 4'd3 && cmd_set) begin
      if (rx_kind == KIND_NONE) begin
        drop = 1'b1;
      end else if (rx_kind == KIND_KP || rx_kind == KIND_KI || rx_kind == KIND_KD) begin
        len_eff = LEN_GAIN;
      end else begin
        len_eff = LEN_BYTE;
      end
    end
  end

  // Bytes 1 through length-3 enter the checksum; byte length-2 is the checksum itself.
  assign add_sum = (byte_count != 4'd0) &&
                   (len_eff == LEN_NONE || ({1'b0, byte_count} + 5'd3) <= {1'b0, len_eff});
  assign last = !drop && len_eff != LEN_NONE && count_inc == len_eff;

  assign chk_idx = IDX_W'(len_eff - 4'd2);
  assign ok = (running_sum == frame_store[chk_idx]);
  assign stored_kind = id_kind(frame_store[3]);

  always_comb begin
    push_rec.is_set = cmd_set;
    push_rec.ok = ok;
    push_rec.seq = frame_store[2];
    push_rec.kind = KIND_NONE;
    push_rec.value = '0;
    if (ok && cmd_set) begin
      push_rec.kind = stored_kind;
      if (stored_kind == KIND_KP || stored_kind == KIND_KI || stored_kind == KIND_KD) begin
        push_rec.value = {frame_store[4], frame_store[5], frame_store[6], frame_store[7]};
      end else begin
        push_rec.value = {24'd0, frame_store[4]};
      end
    end
  end

  assign push = take && last;

  always_comb begin
    byte_count_next = byte_count;
    frame_length_next = frame_length;
    running_sum_next = running_sum;
    if (take) begin
      if (drop || last) begin
        byte_count_next = '0;
        frame_length_next = LEN_NONE;
        running_sum_next = '0;
      end else if ({1'b0, count_inc} >= 5'(FRAME_MAX)) begin
        byte_count_next = '0;
        frame_length_next = LEN_NONE;
        running_sum_next = '0;
      end else begin
        byte_count_next = count_inc;
        frame_length_next = len_eff;
        running_sum_next = add_sum ? running_sum + rx_byte : running_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      frame_length <= LEN_NONE;
      running_sum <= '0;
    end else begin
      byte_count <= byte_count_next;
      frame_length <= frame_length_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_store) begin
      frame_store[byte_count[IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

// ===== src/cfp_queue.sv =====
// Short queue of frame records between the front end and the executor.
module cfp_queue
  import cfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_rec_t push_rec,
  output logic       full,
  input  logic       pop,
  output logic       q_valid,
  output frame_rec_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_rec_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

endmodule

// ===== src/cfp_back.sv =====
// Executor: applies checked frames to the heater state and holds the result register.
module cfp_back
  import cfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  frame_rec_t  head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        command_kind,
  output logic        accepted,
  output logic [7:0]  sequence_byte,
  output logic [2:0]  param_kind,
  output logic [31:0] param_value,
  output logic        power_on
);

  logic power_state;
  logic power_state_next;

  assign pop = q_valid && (!out_valid || out_ready);
  assign power_state_next = power_state ^ (head.ok && !head.is_set);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      power_state <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        power_state <= power_state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      command_kind <= head.is_set;
      accepted <= head.ok;
      sequence_byte <= head.seq;
      param_kind <= head.kind;
      param_value <= head.value;
      power_on <= power_state_next;
    end
  end

endmodule

// ===== src/command_frame_parser.sv =====
// Top level of the command frame parser: front end, record queue and executor.
//
// The block takes one received serial byte per request on the input channel
// (in_valid, in_ready, rx_byte) and assembles command frames. Byte 1 is the
// command, byte 3 the parameter id; together they fix the frame length of 5,
// 7 or 10 bytes. A frame with an unknown command or id is dropped without a
// result and the next byte opens a new frame.
// Each completed frame yields one request on the output channel (out_valid,
// out_ready): command kind, checksum verdict, sequence byte, the parameter
// written and the heater power state after the frame.
// Throughput is one byte per cycle while in_ready is high. With output free,
// a frame result passes the queue and then the output register to out_valid.
// The front end and the executor are joined by a two-entry record queue, so a
// stalled receiver holds up input only once the queue and the output register
// are both full; in_ready then drops until a result is taken.
// Reset clears frame progress, empties the queue and clears the heater state.
module command_frame_parser
  import cfp_pkg::*;
#(
  parameter int FRAME_MAX = FRAME_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        command_kind,
  output logic        accepted,
  output logic [7:0]  sequence_byte,
  output logic [2:0]  param_kind,
  output logic [31:0] param_value,
  output logic        power_on
);

  // Handoff between the front end and the queue.
  logic       push;
  frame_rec_t push_rec;
  logic       q_full;

  // Handoff between the queue and the executor.
  logic       pop;
  logic       q_valid;
  frame_rec_t head;

  // The front end tracks byte position, frame length and checksum, and pushes
  // one record on the last byte of every frame that is not dropped.
  cfp_front #(
    .FRAME_MAX(FRAME_MAX)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .q_full(q_full),
    .push(push),
    .push_rec(push_rec)
  );

  cfp_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_rec(push_rec),
    .full(q_full),
    .pop(pop),
    .q_valid(q_valid),
    .head(head)
  );

  // The executor owns the heater state and toggles it for every accepted
  // power frame, in frame order.
  cfp_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .head(head),
    .pop(pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .command_kind(command_kind),
    .accepted(accepted),
    .sequence_byte(sequence_byte),
    .param_kind(param_kind),
    .param_value(param_value),
    .power_on(power_on)
  );

endmodule
